/* rtl/lmfs_pkg.sv */
// ============================================================================
// lmfs_pkg
// Shared types, codes and the glyph font for the led matrix frame store.
// ============================================================================
package lmfs_pkg;

    localparam int FirstCode = 32;
    localparam int GlyphCols = 5;
    localparam int FontDepth = 96;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PLOT  = 3'd1,
        OP_WRCOL = 3'd2,
        OP_CHAR  = 3'd3,
        OP_DRAW  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_DRAW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;      // input transaction taken this cycle
        logic       glyph_we;  // write one glyph column
        logic       emit;      // load the output register with one column
        logic [2:0] col;       // step counter: glyph column or draw column
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] glyph_width; // zero for ignored codes and the space
        logic       out_free;    // output register empty or being taken
    } t_dp_sts;

    // one glyph per entry, column 0 in the top byte
    localparam logic [39:0] FONT [FontDepth] = '{
        40'h0000000000, 40'hfa00000000, 40'hc000000000, 40'h247e247e24,
        40'h24d4564800, 40'hc6c81026c6, 40'h6c926a040a, 40'hc000000000,
        40'h7c82000000, 40'h827c000000, 40'h107c387c10, 40'h10107c1010,
        40'h0607000000, 40'h1010101000, 40'h0606000000, 40'h0408102040,
        40'h7c8a92a27c, 40'h42fe020000, 40'h468a929262, 40'h449292926c,
        40'h182848fe08, 40'hf49292928c, 40'h3c5292928c, 40'h808e90a0c0,
        40'h6c9292926c, 40'h6092929478, 40'h3636000000, 40'h3637000000,
        40'h1028448200, 40'h2424242424, 40'h8244281000, 40'h60809a9060,
        40'h7c82baaa78, 40'h7e9090907e, 40'hfe9292926c, 40'h7c82828244,
        40'hfe8282827c, 40'hfe92929282, 40'hfe90909080, 40'h7c8292925c,
        40'hfe101010fe, 40'h82fe820000, 40'h0c020202fc, 40'hfe10284482,
        40'hfe02020200, 40'hfe402040fe, 40'hfe402010fe, 40'h7c8282827c,
        40'hfe90909060, 40'h7c82928c7a, 40'hfe90909866, 40'h649292924c,
        40'h8080fe8080, 40'hfc020202fc, 40'hf8040204f8, 40'hfc023c02fc,
        40'hc6281028c6, 40'he0100e10e0, 40'h868a92a2c2, 40'hfe82820000,
        40'h4020100804, 40'h8282fe0000, 40'h2040804020, 40'h0202020202,
        40'hc0e0000000, 40'h042a2a1e00, 40'hfe22221c00, 40'h1c22222200,
        40'h1c2222fc00, 40'h1c2a2a1000, 40'h107e908000, 40'h1825253e00,
        40'hfe20201e00, 40'hbc02000000, 40'h020121be00, 40'hfe08142200,
        40'hfc02000000, 40'h3e2018201e, 40'h3e2020201e, 40'h1c22221c00,
        40'h3f22221c00, 40'h1c22223f00, 40'h221e201000, 40'h122a2a0400,
        40'h207c220400, 40'h3c02023e00, 40'h3804020438, 40'h3c060c063c,
        40'h2214081422, 40'h3905063c00, 40'h262a2a3200, 40'h107c828200,
        40'hee00000000, 40'h82827c1000, 40'h4080408000, 40'h6090906000
    };

    function automatic logic [7:0] font_col(input logic [6:0] idx, input logic [2:0] col);
        logic [39:0] row;
        row = FONT[idx];
        font_col = row[39 - 8 * int'(col) -: 8];
    endfunction

    // number of bytes before the first zero byte
    function automatic logic [2:0] font_len(input logic [6:0] idx);
        logic [39:0] row;
        row = FONT[idx];
        font_len = 3'(GlyphCols);
        for (int k = GlyphCols - 1; k >= 0; k--) begin
            if (row[39 - 8 * k -: 8] == 8'h00) begin
                font_len = 3'(k);
            end
        end
    endfunction

endpackage

/* rtl/led_matrix_frame_store_rotate.sv */
// ============================================================================
// led_matrix_frame_store_rotate
// 8x8 led matrix frame store with glyph drawing and rotated read-out.
// ============================================================================
// Commands arrive on the slave stream, one per transaction. Clear, plot and
// column write finish at the accepting edge and the block is ready again in
// the next cycle. A draw character command then writes its glyph columns (up
// to five; none for control codes and the space) from the font table into the
// store. A draw frame command walks the eight columns with one step counter,
// one column per cycle while the output register is free, and puts each into
// the output register. Result columns leave in order 0..7 with tlast on
// column 7. The output register holds a column while tready is low; the
// sequencer stalls on it, and a new command may be taken while the final
// column of a draw still waits. Rotation is to be written on the config port
// only while idle; the block itself does not enforce this. It only changes
// how a draw reads the store. Reset clears the store, sets rotation to zero,
// returns the sequencer to idle and drops the output valid.
// ============================================================================
module led_matrix_frame_store_rotate
    import lmfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], column_index[5:3], row_bit[8:6], pixel_on[9], column_byte[17:10],
    // char_code[24:18], centred[25], zero fill [31:26]
    input  logic [31:0] s_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_column[2:0], led_data[10:3], zero fill [15:11]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic [2:0] w_out_col;
    logic [7:0] w_led;

    lmfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tdata[2:0]),
        .i_sts   (w_sts),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    lmfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (s_axis_tdata[25:0]),
        .i_rot_we     (i_cfg_we),
        .i_rot        (i_cfg_wdata),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_column (w_out_col),
        .o_led_data   (w_led),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_led, w_out_col};

endmodule

/* rtl/lmfs_ctrl.sv */
// ============================================================================
// lmfs_ctrl
// Command sequencer: takes items, steps glyph writes and frame draws.
// ============================================================================
module lmfs_ctrl
    import lmfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [2:0] i_op,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       w_accept;
    logic       w_glyph_end;

    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign w_glyph_end = ({1'b0, r_cnt} + 4'd1) >= {1'b0, i_sts.glyph_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_op))
                        OP_CHAR: n_state = ST_GLYPH;
                        OP_DRAW: n_state = ST_DRAW;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_GLYPH: begin
                if (w_glyph_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if (i_sts.out_free && (r_cnt == 3'd7)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // step counter
    always_comb begin
        unique case (r_state)
            ST_GLYPH: n_cnt = r_cnt + 3'd1;
            ST_DRAW:  n_cnt = i_sts.out_free ? r_cnt + 3'd1 : r_cnt;
            default:  n_cnt = '0;
        endcase
    end

    // outputs
    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_cmd.load     = w_accept;
        o_cmd.glyph_we = (r_state == ST_GLYPH) && (r_cnt < i_sts.glyph_width);
        o_cmd.emit     = (r_state == ST_DRAW) && i_sts.out_free;
        o_cmd.col      = r_cnt;
    end

endmodule

/* rtl/lmfs_dp.sv */
// ============================================================================
// lmfs_dp
// Frame store, glyph lookup, rotated read-out and the output register.
// ============================================================================
module lmfs_dp
    import lmfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [25:0] i_item,
    input  logic        i_rot_we,
    input  logic [1:0]  i_rot,
    input  logic        i_out_ready,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    output logic [2:0]  o_out_column,
    output logic [7:0]  o_led_data,
    output logic        o_out_last
);

    logic [7:0] r_fs [8];
    logic [1:0] r_rot;
    logic [6:0] r_code;
    logic       r_centred;
    logic       r_ovalid;
    logic [2:0] r_out_col;
    logic [7:0] r_led;
    logic       r_last;

    logic [2:0] w_op;
    logic [2:0] w_col;
    logic [2:0] w_row;
    logic       w_on;
    logic [7:0] w_byte;
    logic [6:0] w_idx;
    logic [2:0] w_len;
    logic [2:0] w_delta;
    logic [2:0] w_gaddr;
    logic [7:0] w_view;
    logic [2:0] w_i;

    assign w_op   = i_item[2:0];
    assign w_col  = i_item[5:3];
    assign w_row  = i_item[8:6];
    assign w_on   = i_item[9];
    assign w_byte = i_item[17:10];

    // codes below the first printable one have no glyph
    assign w_idx   = r_code - 7'(FirstCode);
    assign w_len   = (r_code < 7'(FirstCode)) ? 3'd0 : font_len(w_idx);
    assign w_delta = r_centred ? 3'((4'd8 - {1'b0, w_len}) >> 1) : 3'd0;
    assign w_gaddr = i_cmd.col + w_delta;

    assign o_sts.glyph_width = w_len;
    assign o_sts.out_free    = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= 2'(ROT_0);
        end else if (i_rot_we) begin
            r_rot <= i_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code    <= i_item[24:18];
            r_centred <= i_item[25];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_fs[k] <= '0;
            end
        end else if (i_cmd.load) begin
            unique case (t_op'(w_op))
                OP_CLEAR: begin
                    for (int k = 0; k < 8; k++) begin
                        r_fs[k] <= '0;
                    end
                end
                OP_PLOT:  r_fs[w_col][w_row] <= w_on;
                OP_WRCOL: r_fs[w_col] <= w_byte;
                default:  ;
            endcase
        end else if (i_cmd.glyph_we) begin
            r_fs[w_gaddr] <= font_col(w_idx, i_cmd.col);
        end
    end

    // one column of the rotated view, picked by the draw counter
    assign w_i = i_cmd.col;
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            unique case (t_rot'(r_rot))
                ROT_0:   w_view[j] = r_fs[w_i][j];
                ROT_90:  w_view[j] = r_fs[j][~w_i];
                ROT_180: w_view[j] = r_fs[~w_i][7 - j];
                ROT_270: w_view[j] = r_fs[7 - j][w_i];
                default: w_view[j] = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_col <= i_cmd.col;
            r_led     <= {w_view[0], w_view[7:1]};
            r_last    <= (i_cmd.col == 3'd7);
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_column = r_out_col;
    assign o_led_data   = r_led;
    assign o_out_last   = r_last;

endmodule

/* rtl/lmfs_chk.sv */
// ============================================================================
// lmfs_chk
// Port-level checks for the led matrix frame store, bound to the top level.
// ============================================================================
module lmfs_chk
    import lmfs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled column holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // tlast marks exactly the last column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd7)))
        else $error("tlast does not match column 7");

    // a draw keeps the input side busy in the next cycle
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:0] == 3'(OP_DRAW)) |=>
            !s_axis_tready)
        else $error("input ready right after a draw");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind led_matrix_frame_store_rotate lmfs_chk u_lmfs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the led matrix frame store with rotated read-out.
// A directed command list and random command phases under each rotation
// are sent on the slave stream. A class model keeps its own frame copy and
// rotation, and queues the eight columns of every draw. Each result
// transaction is compared field by field against the oldest queued column.
// Both stream sides idle at random, except for one phase with no gaps.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lmfs_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int SettleCycles = 12;

    // command codes with no function
    localparam logic [2:0] OP_NONE_5 = 3'd5;
    localparam logic [2:0] OP_NONE_6 = 3'd6;
    localparam logic [2:0] OP_NONE_7 = 3'd7;

    localparam t_rot PHASE_ROT [4] = '{ROT_90, ROT_180, ROT_270, ROT_0};

    // glyph columns from code 32 up, first column in the top byte
    localparam logic [39:0] GLYPHS [96] = '{
        40'h0000000000, 40'hfa00000000, 40'hc000000000, 40'h247e247e24,
        40'h24d4564800, 40'hc6c81026c6, 40'h6c926a040a, 40'hc000000000,
        40'h7c82000000, 40'h827c000000, 40'h107c387c10, 40'h10107c1010,
        40'h0607000000, 40'h1010101000, 40'h0606000000, 40'h0408102040,
        40'h7c8a92a27c, 40'h42fe020000, 40'h468a929262, 40'h449292926c,
        40'h182848fe08, 40'hf49292928c, 40'h3c5292928c, 40'h808e90a0c0,
        40'h6c9292926c, 40'h6092929478, 40'h3636000000, 40'h3637000000,
        40'h1028448200, 40'h2424242424, 40'h8244281000, 40'h60809a9060,
        40'h7c82baaa78, 40'h7e9090907e, 40'hfe9292926c, 40'h7c82828244,
        40'hfe8282827c, 40'hfe92929282, 40'hfe90909080, 40'h7c8292925c,
        40'hfe101010fe, 40'h82fe820000, 40'h0c020202fc, 40'hfe10284482,
        40'hfe02020200, 40'hfe402040fe, 40'hfe402010fe, 40'h7c8282827c,
        40'hfe90909060, 40'h7c82928c7a, 40'hfe90909866, 40'h649292924c,
        40'h8080fe8080, 40'hfc020202fc, 40'hf8040204f8, 40'hfc023c02fc,
        40'hc6281028c6, 40'he0100e10e0, 40'h868a92a2c2, 40'hfe82820000,
        40'h4020100804, 40'h8282fe0000, 40'h2040804020, 40'h0202020202,
        40'hc0e0000000, 40'h042a2a1e00, 40'hfe22221c00, 40'h1c22222200,
        40'h1c2222fc00, 40'h1c2a2a1000, 40'h107e908000, 40'h1825253e00,
        40'hfe20201e00, 40'hbc02000000, 40'h020121be00, 40'hfe08142200,
        40'hfc02000000, 40'h3e2018201e, 40'h3e2020201e, 40'h1c22221c00,
        40'h3f22221c00, 40'h1c22223f00, 40'h221e201000, 40'h122a2a0400,
        40'h207c220400, 40'h3c02023e00, 40'h3804020438, 40'h3c060c063c,
        40'h2214081422, 40'h3905063c00, 40'h262a2a3200, 40'h107c828200,
        40'hee00000000, 40'h82827c1000, 40'h4080408000, 40'h6090906000
    };

    class led_frame_predictor;
        typedef struct packed {
            logic [2:0] col;
            logic [7:0] led;
            logic       last;
        } column_t;

        logic [7:0] frame [8];
        t_rot       rot;
        column_t    expected_columns [$];
        int         errors;

        function new();
            foreach (frame[i]) frame[i] = 8'h00;
            rot = ROT_0;
            errors = 0;
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void paint_glyph(logic [6:0] code, logic centred);
            int         idx;
            int         len;
            int         delta;
            logic [39:0] bits;
            if (code < FirstCode) return;
            idx = int'(code) - FirstCode;
            bits = GLYPHS[idx];
            len = 0;
            while (len < 5 && bits[39 - 8 * len -: 8] != 8'h00) len++;
            delta = centred ? (8 - len) / 2 : 0;
            for (int i = 0; i < len; i++) frame[(i + delta) % 8] = bits[39 - 8 * i -: 8];
        endfunction

        // read the frame through the rotation, one-bit right rotate per column
        function void queue_draw();
            logic [7:0] view [8];
            column_t    c;
            foreach (view[i]) view[i] = 8'h00;
            for (int y = 0; y < 8; y++) begin
                for (int x = 0; x < 8; x++) begin
                    if (frame[y][x]) begin
                        case (rot)
                            ROT_0:   view[y][x] = 1'b1;
                            ROT_90:  view[7 - x][y] = 1'b1;
                            ROT_180: view[7 - y][7 - x] = 1'b1;
                            default: view[x][7 - y] = 1'b1;
                        endcase
                    end
                end
            end
            for (int i = 0; i < 8; i++) begin
                c.col = 3'(i);
                c.led = {view[i][0], view[i][7:1]};
                c.last = (i == 7);
                expected_columns.push_back(c);
            end
        endfunction

        function void take_command(logic [31:0] word);
            logic [2:0] col;
            logic [2:0] row;
            col = word[5:3];
            row = word[8:6];
            case (word[2:0])
                OP_CLEAR: foreach (frame[i]) frame[i] = 8'h00;
                OP_PLOT:  frame[col][row] = word[9];
                OP_WRCOL: frame[col] = word[17:10];
                OP_CHAR:  paint_glyph(word[24:18], word[25]);
                OP_DRAW:  queue_draw();
                default:  ;
            endcase
        endfunction

        function void check_column(logic [15:0] data, logic tlast);
            column_t e;
            if (expected_columns.size() == 0) begin
                report($sformatf("unexpected column col=%0d led=%02h last=%0b",
                                 data[2:0], data[10:3], tlast));
                return;
            end
            e = expected_columns.pop_front();
            if (data[2:0] !== e.col || data[10:3] !== e.led || tlast !== e.last) begin
                report($sformatf("expected col=%0d led=%02h last=%0b, got col=%0d led=%02h last=%0b",
                                 e.col, e.led, e.last, data[2:0], data[10:3], tlast));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic        steady = 1'b0;
    int          cycle_count = 0;

    led_frame_predictor board = new();

    led_matrix_frame_store_rotate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) board.take_command(s_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) board.check_column(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
    end

    // cmd, column_index, row_bit, pixel_on, column_byte, char_code, centred
    function automatic logic [31:0] pack_cmd(logic [2:0] op, logic [2:0] col, logic [2:0] row,
                                             logic on_bit, logic [7:0] col_byte,
                                             logic [6:0] code, logic centred);
        return {6'b0, centred, code, col_byte, on_bit, row, col, op};
    endfunction

    function automatic logic [31:0] random_command();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 4)       op = OP_CLEAR;
        else if (pick < 28) op = OP_PLOT;
        else if (pick < 48) op = OP_WRCOL;
        else if (pick < 72) op = OP_CHAR;
        else if (pick < 94) op = OP_DRAW;
        else                op = 3'($urandom_range(OP_NONE_5, OP_NONE_7));
        return pack_cmd(op, 3'($urandom), 3'($urandom), 1'($urandom), 8'($urandom),
                        7'($urandom), 1'($urandom));
    endfunction

    task automatic push_command(input logic [31:0] word);
        while (!steady && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // let the last glyph write finish before touching the register
    task automatic load_rotation(input t_rot r);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        board.rot = r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_rotation(ROT_0);

        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_WRCOL, 3'd0, 3'd0, 1'b0, 8'hff, 7'd0, 1'b0));
        push_command(pack_cmd(OP_WRCOL, 3'd7, 3'd7, 1'b1, 8'h81, 7'd127, 1'b1));
        push_command(pack_cmd(OP_PLOT, 3'd3, 3'd7, 1'b1, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_PLOT, 3'd5, 3'd0, 1'b1, 8'hff, 7'd0, 1'b0));
        push_command(pack_cmd(OP_PLOT, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_DRAW, 3'd7, 3'd7, 1'b1, 8'hff, 7'd127, 1'b1));
        // control codes and the space leave the frame alone
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd31, 1'b1));
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd32, 1'b1));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd65, 1'b0));
        // single-column glyph, centred to column 3
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd33, 1'b1));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd127, 1'b1));
        push_command(pack_cmd(OP_CHAR, 3'd0, 3'd0, 1'b0, 8'h00, 7'd48, 1'b1));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_NONE_5, 3'd7, 3'd7, 1'b1, 8'hff, 7'd127, 1'b1));
        push_command(pack_cmd(OP_NONE_6, 3'd2, 3'd5, 1'b0, 8'h5a, 7'd70, 1'b0));
        push_command(pack_cmd(OP_NONE_7, 3'd7, 3'd7, 1'b1, 8'hff, 7'd127, 1'b1));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_CLEAR, 3'd7, 3'd7, 1'b1, 8'hff, 7'd127, 1'b1));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));
        push_command(pack_cmd(OP_WRCOL, 3'd2, 3'd0, 1'b0, 8'ha5, 7'd0, 1'b0));
        push_command(pack_cmd(OP_DRAW, 3'd0, 3'd0, 1'b0, 8'h00, 7'd0, 1'b0));

        for (int p = 0; p < 5; p++) begin
            load_rotation(p < 4 ? PHASE_ROT[p] : t_rot'($urandom_range(0, 3)));
            steady <= (p == 2);
            repeat (100) push_command(random_command());
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lmfs_pkg.sv
rtl/lmfs_ctrl.sv
rtl/lmfs_dp.sv
rtl/led_matrix_frame_store_rotate.sv
rtl/lmfs_chk.sv
test/tb.sv
